// ===== hdl/lls_pkg.sv =====
// Shared types and constants for the line literal substitution block.
// Depends on nothing; every other file in hdl imports it.
`timescale 1ns / 1ps
`default_nettype none

package lls_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIND_BYTES     = 3'd0,
      CSR_FIND_LENGTH    = 3'd1,
      CSR_REPLACE_BYTES  = 3'd2,
      CSR_REPLACE_LENGTH = 3'd3,
      CSR_REPLACE_ALL    = 3'd4,
      CSR_ADDRESS_MODE   = 3'd5,
      CSR_ADDRESS_LINE   = 3'd6
   } lls_csr_type;

   typedef enum logic [1:0] {
      ADDR_EVERY      = 2'd0,
      ADDR_NUMBERED   = 2'd1,
      ADDR_FINAL_LINE = 2'd2
   } lls_addr_mode_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  data_byte;
      logic        line_end;
      logic        last_line;
      logic        file_start;
   } lls_req_type;

   typedef struct packed {
      logic        out_has_byte;
      logic [7:0]  out_byte;
      logic        out_line_end;
      logic        last;
   } lls_rsp_type;

   typedef struct packed {
      logic [63:0] find_bytes;
      logic [3:0]  find_length;
      logic [63:0] replace_bytes;
      logic [3:0]  replace_length;
      logic        replace_all;
      logic [1:0]  address_mode;
      logic [23:0] address_line;
   } lls_cfg_type;

endpackage

`default_nettype wire

// ===== hdl/line_literal_substitution.sv =====
// Path: an item's first result goes from the plan register to the output register.
// Throughput: one item per cycle while each item gives at most one result and
// the output is not stalled; an item with more results holds the request side
// until the plan register, drained one result per unstalled cycle, holds its final one.
// Reset: clears configuration (address_line to 1), pending count and flags; line count to 1.
// Top level: configuration registers, match engine and result drain.
`timescale 1ns / 1ps
`default_nettype none

module line_literal_substitution
   import lls_pkg::*;
#(
   parameter int FIND_MAX        = 8,
   parameter int REPLACE_MAX     = 8,
   parameter int LINE_COUNT_BITS = 24
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire lls_req_type             req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output lls_rsp_type                  rsp_data,
   input  wire logic                    csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FL_W = $clog2(FIND_MAX + 1);
   localparam int RL_W = $clog2(REPLACE_MAX + 1);

   lls_cfg_type                  cfg_ff, cfg_in;

   logic                         plan_free;
   logic                         accept;
   logic [FIND_MAX-1:0][7:0]     plan_a_bytes;
   logic [FL_W-1:0]              plan_a_count;
   logic [REPLACE_MAX-1:0][7:0]  plan_b_bytes;
   logic [RL_W-1:0]              plan_b_count;
   logic [FIND_MAX-1:0][7:0]     plan_c_bytes;
   logic [FL_W-1:0]              plan_c_count;
   logic                         plan_line_end;

   // Register writes: keep each register's own width, drop indexes past the list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (lls_csr_type'(csr_index))
            CSR_FIND_BYTES:     cfg_in.find_bytes     = csr_wdata;
            CSR_FIND_LENGTH:    cfg_in.find_length    = csr_wdata[3:0];
            CSR_REPLACE_BYTES:  cfg_in.replace_bytes  = csr_wdata;
            CSR_REPLACE_LENGTH: cfg_in.replace_length = csr_wdata[3:0];
            CSR_REPLACE_ALL:    cfg_in.replace_all    = csr_wdata[0];
            CSR_ADDRESS_MODE:   cfg_in.address_mode   = csr_wdata[1:0];
            CSR_ADDRESS_LINE:   cfg_in.address_line   = csr_wdata[23:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{find_bytes: 64'd0, find_length: 4'd0, replace_bytes: 64'd0,
                     replace_length: 4'd0, replace_all: 1'b0, address_mode: 2'd0,
                     address_line: 24'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a new item once the plan register empties, or as its final result
   // moves to the output register in this cycle.
   always_comb begin
      req_stall = !plan_free;
      accept    = req_valid && plan_free;
   end

   // Work out every result of the item and advance window and line state.
   lls_engine #(
      .FIND_MAX        (FIND_MAX),
      .REPLACE_MAX     (REPLACE_MAX),
      .LINE_COUNT_BITS (LINE_COUNT_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_data),
      .cfg           (cfg_ff),
      .plan_a_bytes  (plan_a_bytes),
      .plan_a_count  (plan_a_count),
      .plan_b_bytes  (plan_b_bytes),
      .plan_b_count  (plan_b_count),
      .plan_c_bytes  (plan_c_bytes),
      .plan_c_count  (plan_c_count),
      .plan_line_end (plan_line_end)
   );

   // Hold the plan and hand out one result per transfer.
   lls_drain #(
      .FIND_MAX    (FIND_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_drain (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .plan_a_bytes  (plan_a_bytes),
      .plan_a_count  (plan_a_count),
      .plan_b_bytes  (plan_b_bytes),
      .plan_b_count  (plan_b_count),
      .plan_c_bytes  (plan_c_bytes),
      .plan_c_count  (plan_c_count),
      .plan_line_end (plan_line_end),
      .plan_free     (plan_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

`ifndef ASSERT_OFF
   a_address_line_reset: assert property (@(posedge clock)
      $past(reset) |-> cfg_ff.address_line == 24'd1 && cfg_ff.find_length == 4'd0)
      else $error("configuration did not return to its reset values");
`endif

endmodule

`default_nettype wire

// ===== hdl/lls_engine.sv =====
// Match engine: pending window, line counter and per-item result plan.
// Depends on lls_pkg for the request and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module lls_engine
   import lls_pkg::*;
#(
   parameter int FIND_MAX        = 8,
   parameter int REPLACE_MAX     = 8,
   parameter int LINE_COUNT_BITS = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire lls_req_type                        req,
   input  wire lls_cfg_type                        cfg,
   output logic [FIND_MAX-1:0][7:0]                plan_a_bytes,
   output logic [$clog2(FIND_MAX+1)-1:0]           plan_a_count,
   output logic [REPLACE_MAX-1:0][7:0]             plan_b_bytes,
   output logic [$clog2(REPLACE_MAX+1)-1:0]        plan_b_count,
   output logic [FIND_MAX-1:0][7:0]                plan_c_bytes,
   output logic [$clog2(FIND_MAX+1)-1:0]           plan_c_count,
   output logic                                    plan_line_end
);

   localparam int FL_W  = $clog2(FIND_MAX + 1);
   localparam int RL_W  = $clog2(REPLACE_MAX + 1);
   localparam int CMP_W = (LINE_COUNT_BITS > 24) ? LINE_COUNT_BITS : 24;
   localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = {LINE_COUNT_BITS{1'b1}};

   logic [FIND_MAX-1:0][7:0]     window_ff, window_in;
   logic [FL_W-1:0]              count_ff, count_in;
   logic [LINE_COUNT_BITS-1:0]   line_ff, line_in;
   logic                         replaced_ff, replaced_in;

   logic [FL_W-1:0]              flen;
   logic [RL_W-1:0]              rlen;
   logic [LINE_COUNT_BITS-1:0]   line_cur;
   logic                         repl_cur;
   logic                         hit;
   logic                         active;
   logic                         flushed;
   logic [FL_W-1:0]              p2;
   logic [FL_W-1:0]              q;
   logic [FIND_MAX-1:0][7:0]     win_app;
   logic [FIND_MAX-1:0][7:0]     win_shift;
   logic                         full;
   logic                         differ;
   logic                         matched;
   logic [FL_W-1:0]              cnt_new;

   always_comb begin
      flen = (32'(cfg.find_length) > FIND_MAX) ? FL_W'(FIND_MAX) : FL_W'(cfg.find_length);
      rlen = (32'(cfg.replace_length) > REPLACE_MAX) ?
             RL_W'(REPLACE_MAX) : RL_W'(cfg.replace_length);

      line_cur = req.file_start ? LINE_COUNT_BITS'(1) : line_ff;
      repl_cur = req.file_start ? 1'b0 : replaced_ff;

      case (cfg.address_mode)
         ADDR_EVERY:      hit = 1'b1;
         ADDR_NUMBERED:   hit = (CMP_W'(line_cur) == CMP_W'(cfg.address_line));
         ADDR_FINAL_LINE: hit = req.last_line;
         default:         hit = 1'b0;
      endcase

      active  = (flen != '0) && hit && (cfg.replace_all || !repl_cur);
      flushed = req.file_start || (req.has_byte && (!active || count_ff >= flen));
      p2      = flushed ? '0 : count_ff;
      q       = p2 + FL_W'(1);

      for (int i = 0; i < FIND_MAX; i++) begin
         win_app[i] = (i == p2) ? req.data_byte : window_ff[i];
      end
      for (int i = 0; i < FIND_MAX; i++) begin
         win_shift[i] = (i < FIND_MAX - 1) ? win_app[(i + 1) % FIND_MAX] : 8'h00;
      end

      differ = 1'b0;
      for (int i = 0; i < FIND_MAX; i++) begin
         if ((i < flen) && (win_app[i] != cfg.find_bytes[8*i +: 8])) begin
            differ = 1'b1;
         end
      end

      full    = req.has_byte && active && (q == flen);
      matched = full && !differ;

      // byte segment: pass-through, evicted oldest byte, or replacement
      plan_b_bytes = '0;
      plan_b_count = '0;
      if (req.has_byte && !active) begin
         plan_b_bytes[0] = req.data_byte;
         plan_b_count    = RL_W'(1);
      end else if (matched) begin
         for (int i = 0; i < REPLACE_MAX; i++) begin
            plan_b_bytes[i] = cfg.replace_bytes[8*i +: 8];
         end
         plan_b_count = rlen;
      end else if (full) begin
         plan_b_bytes[0] = win_app[0];
         plan_b_count    = RL_W'(1);
      end

      if (!req.has_byte || !active) begin
         cnt_new = p2;
      end else if (matched) begin
         cnt_new = '0;
      end else if (full) begin
         cnt_new = q - FL_W'(1);
      end else begin
         cnt_new = q;
      end

      window_in = (full && !matched) ? win_shift : win_app;

      plan_a_bytes  = window_ff;
      plan_a_count  = flushed ? count_ff : '0;
      plan_c_bytes  = window_in;
      plan_c_count  = req.line_end ? cnt_new : '0;
      plan_line_end = req.line_end;

      count_in    = req.line_end ? '0 : cnt_new;
      replaced_in = req.line_end ? 1'b0 : (matched | repl_cur);
      line_in     = (req.line_end && line_cur != LINE_MAX) ?
                    line_cur + LINE_COUNT_BITS'(1) : line_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         line_ff     <= LINE_COUNT_BITS'(1);
         replaced_ff <= 1'b0;
      end else if (accept) begin
         count_ff    <= count_in;
         line_ff     <= line_in;
         replaced_ff <= replaced_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_below_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) < FIND_MAX)
      else $error("pending count reached the window size");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.line_end |=> count_ff == '0 && !replaced_ff)
      else $error("line end left pending bytes or the replaced flag");
`endif

endmodule

`default_nettype wire

// ===== hdl/lls_drain.sv =====
// Plan and output registers: walk one item's plan one result a cycle unless stalled.
// Depends on lls_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module lls_drain
   import lls_pkg::*;
#(
   parameter int FIND_MAX    = 8,
   parameter int REPLACE_MAX = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire logic [FIND_MAX-1:0][7:0]           plan_a_bytes,
   input  wire logic [$clog2(FIND_MAX+1)-1:0]      plan_a_count,
   input  wire logic [REPLACE_MAX-1:0][7:0]        plan_b_bytes,
   input  wire logic [$clog2(REPLACE_MAX+1)-1:0]   plan_b_count,
   input  wire logic [FIND_MAX-1:0][7:0]           plan_c_bytes,
   input  wire logic [$clog2(FIND_MAX+1)-1:0]      plan_c_count,
   input  wire logic                               plan_line_end,
   output logic                                    plan_free,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output lls_rsp_type                             rsp_data
);

   localparam int FL_W  = $clog2(FIND_MAX + 1);
   localparam int RL_W  = $clog2(REPLACE_MAX + 1);
   localparam int TOT_W = $clog2(2 * FIND_MAX + REPLACE_MAX + 2);

   logic [FIND_MAX-1:0][7:0]     a_q_ff, a_q_in;
   logic [FL_W-1:0]              a_n_ff, a_n_in;
   logic [REPLACE_MAX-1:0][7:0]  b_q_ff, b_q_in;
   logic [RL_W-1:0]              b_n_ff, b_n_in;
   logic [FIND_MAX-1:0][7:0]     c_q_ff, c_q_in;
   logic [FL_W-1:0]              c_n_ff, c_n_in;
   logic                         le_ff, le_in;
   logic [TOT_W-1:0]             total_ff, total_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lls_rsp_type                  rsp_data_ff, rsp_data_in;

   logic                         busy;
   logic                         out_load;
   lls_rsp_type                  head;

   always_comb begin
      busy      = (total_ff != '0);
      out_load  = busy && (!rsp_valid_ff || !rsp_stall);
      plan_free = !busy || (total_ff == TOT_W'(1) && out_load);

      // pick the head of the first non-empty segment and advance that segment
      a_q_in = a_q_ff;
      a_n_in = a_n_ff;
      b_q_in = b_q_ff;
      b_n_in = b_n_ff;
      c_q_in = c_q_ff;
      c_n_in = c_n_ff;
      le_in  = le_ff;
      head   = '0;
      head.last = (total_ff == TOT_W'(1));
      if (a_n_ff != '0) begin
         head.out_has_byte = 1'b1;
         head.out_byte     = a_q_ff[0];
         for (int i = 0; i < FIND_MAX - 1; i++) a_q_in[i] = a_q_ff[i + 1];
         a_n_in = a_n_ff - FL_W'(1);
      end else if (b_n_ff != '0) begin
         head.out_has_byte = 1'b1;
         head.out_byte     = b_q_ff[0];
         for (int i = 0; i < REPLACE_MAX - 1; i++) b_q_in[i] = b_q_ff[i + 1];
         b_n_in = b_n_ff - RL_W'(1);
      end else if (c_n_ff != '0) begin
         head.out_has_byte = 1'b1;
         head.out_byte     = c_q_ff[0];
         for (int i = 0; i < FIND_MAX - 1; i++) c_q_in[i] = c_q_ff[i + 1];
         c_n_in = c_n_ff - FL_W'(1);
      end else begin
         head.out_line_end = le_ff;
         le_in = 1'b0;
      end
      total_in = total_ff - TOT_W'(1);

      if (load) begin
         a_q_in   = plan_a_bytes;
         a_n_in   = plan_a_count;
         b_q_in   = plan_b_bytes;
         b_n_in   = plan_b_count;
         c_q_in   = plan_c_bytes;
         c_n_in   = plan_c_count;
         le_in    = plan_line_end;
         total_in = TOT_W'(plan_a_count) + TOT_W'(plan_b_count) +
                    TOT_W'(plan_c_count) + TOT_W'(plan_line_end);
      end else if (!out_load) begin
         a_n_in   = a_n_ff;
         b_n_in   = b_n_ff;
         c_n_in   = c_n_ff;
         le_in    = le_ff;
         total_in = total_ff;
      end

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = out_load ? head : rsp_data_ff;

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_n_ff       <= '0;
         b_n_ff       <= '0;
         c_n_ff       <= '0;
         le_ff        <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_n_ff       <= a_n_in;
         b_n_ff       <= b_n_in;
         c_n_ff       <= c_n_in;
         le_ff        <= le_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load || out_load) begin
         a_q_ff <= a_q_in;
         b_q_ff <= b_q_in;
         c_q_ff <= c_q_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_total_consistent: assert property (@(posedge clock) disable iff (reset)
      total_ff == TOT_W'(a_n_ff) + TOT_W'(b_n_ff) + TOT_W'(c_n_ff) + TOT_W'(le_ff))
      else $error("plan total disagrees with segment counts");

   a_queued_reaches_output: assert property (@(posedge clock) disable iff (reset)
      busy && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("queued result did not move to the output register");
`endif

endmodule

`default_nettype wire

// ===== sim/line_literal_substitution_tb.sv =====
// Self-checking testbench for line_literal_substitution: directed table then random text files.
// Depends on lls_pkg and the line_literal_substitution top level in hdl; nothing else.
`timescale 1ns / 1ps

module line_literal_substitution_tb;
   import lls_pkg::*;

   localparam int          FIND_MAX      = 8;
   localparam int          REPLACE_MAX   = 8;
   localparam logic [23:0] LINE_MAX      = 24'hFF_FFFF;
   localparam logic [1:0]  ADDR_UNUSED   = 2'd3;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_ITEMS   = 18;
   localparam int          QUIET_CYCLES  = 6;
   localparam int          CYCLE_LIMIT   = 200_000;
   localparam int          IDLE_PERCENT  = 37;

   // How a directed row gets its expectation: from the predictor, typed as nothing, or
   // typed as exactly one result.
   typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_ONE} want_kind_type;
   typedef enum logic {ROW_SEND, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      lls_req_type   item;
      want_kind_type want_kind;
      lls_rsp_type   want;
      lls_csr_type   reg_index;
      logic [63:0]   value;
   } dir_row_type;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_stall;
   lls_req_type   req_data     = '0;
   logic          rsp_valid;
   logic          rsp_stall    = 1'b0;
   lls_rsp_type   rsp_data;
   logic          csr_write_en = 1'b0;
   lls_csr_type   csr_index    = CSR_FIND_BYTES;
   logic [63:0]   csr_wdata    = '0;

   // Travel alongside req_data so the monitor knows how the row in flight is checked.
   want_kind_type row_want_kind = WANT_MODEL;
   lls_rsp_type   row_want      = '0;

   logic          calm        = 1'b0;
   int            failures    = 0;
   int            cycle_count = 0;

   // Predictor copy of the configuration and of the line state.
   lls_cfg_type   cfg;
   logic [7:0]    held_bytes [FIND_MAX];
   int            held_n;
   logic [23:0]   line_no;
   logic          replaced;

   lls_rsp_type   step_text [$];
   lls_rsp_type   awaited_text [$];
   lls_req_type   stim_items [$];
   dir_row_type   directed_rows [$];

   line_literal_substitution u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void emit_text(logic hb, logic [7:0] b, logic le);
      lls_rsp_type r;
      r.out_has_byte = hb;
      r.out_byte     = hb ? b : 8'h00;
      r.out_line_end = le;
      r.last         = 1'b0;
      step_text.push_back(r);
   endfunction

   // Send every held byte out unchanged and empty the window.
   function automatic void drain_held();
      int i;
      for (i = 0; i < held_n; i++)
         emit_text(1'b1, held_bytes[i], 1'b0);
      held_n = 0;
   endfunction

   // Work out every result that one accepted item causes, in order, into step_text.
   function automatic void apply_substitution(lls_req_type it);
      int   flen, rlen, i;
      logic hit, active, same;
      step_text.delete();
      flen = (cfg.find_length > FIND_MAX) ? FIND_MAX : cfg.find_length;
      rlen = (cfg.replace_length > REPLACE_MAX) ? REPLACE_MAX : cfg.replace_length;

      // file start first: flush without a line end and restart the count
      if (it.file_start) begin
         drain_held();
         line_no  = 24'd1;
         replaced = 1'b0;
      end

      if (it.has_byte) begin
         case (cfg.address_mode)
            ADDR_EVERY:      hit = 1'b1;
            ADDR_NUMBERED:   hit = (line_no == cfg.address_line);
            ADDR_FINAL_LINE: hit = it.last_line;
            default:         hit = 1'b0;
         endcase
         active = (flen != 0) && hit && (cfg.replace_all || !replaced);
         if (!active) begin
            drain_held();
            emit_text(1'b1, it.data_byte, 1'b0);
         end else begin
            // the pattern may have shrunk under a partly filled window
            if (held_n >= flen)
               drain_held();
            held_bytes[held_n] = it.data_byte;
            held_n++;
            if (held_n == flen) begin
               same = 1'b1;
               for (i = 0; i < flen; i++)
                  if (held_bytes[i] != cfg.find_bytes[8*i +: 8])
                     same = 1'b0;
               if (same) begin
                  for (i = 0; i < rlen; i++)
                     emit_text(1'b1, cfg.replace_bytes[8*i +: 8], 1'b0);
                  held_n   = 0;
                  replaced = 1'b1;
               end else begin
                  // release the oldest byte and slide the window by one
                  emit_text(1'b1, held_bytes[0], 1'b0);
                  for (i = 0; i < held_n - 1; i++)
                     held_bytes[i] = held_bytes[i + 1];
                  held_n--;
               end
            end
         end
      end

      if (it.line_end) begin
         drain_held();
         emit_text(1'b0, 8'h00, 1'b1);
         if (line_no != LINE_MAX)
            line_no++;
         replaced = 1'b0;
      end

      if (step_text.size() != 0)
         step_text[step_text.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: check result transfers, predict on request transfers
   // ------------------------------------------------------------------

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      lls_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_text.size() == 0) begin
               $error("result transfer with nothing awaited: %h", rsp_data);
               failures++;
            end else begin
               want = awaited_text.pop_front();
               compare_field("out_has_byte", want.out_has_byte, rsp_data.out_has_byte);
               compare_field("out_byte", want.out_byte, rsp_data.out_byte);
               compare_field("out_line_end", want.out_line_end, rsp_data.out_line_end);
               compare_field("last", want.last, rsp_data.last);
            end
         end
         if (req_valid && !req_stall) begin
            // keep the predictor state moving even where the row types its own result
            apply_substitution(req_data);
            case (row_want_kind)
               WANT_MODEL: foreach (step_text[i]) awaited_text.push_back(step_text[i]);
               WANT_ONE:   awaited_text.push_back(row_want);
               default:    ;
            endcase
         end
      end
   end

   // Receiver: stall at random unless a calm stretch is running.
   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Watchdog: give up well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("line_literal_substitution test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Present one item, with a random gap first, and hold it until the transfer.
   task automatic send_item(input lls_req_type item, input want_kind_type wk,
                            input lls_rsp_type want);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < IDLE_PERCENT) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data      <= item;
      row_want_kind <= wk;
      row_want      <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold off until every awaited result has come, then let the
   // pipeline settle, since an item may still be in flight that gives no result.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_text.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input lls_csr_type idx, input logic [63:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FIND_BYTES:     cfg.find_bytes     = val;
         CSR_FIND_LENGTH:    cfg.find_length    = val[3:0];
         CSR_REPLACE_BYTES:  cfg.replace_bytes  = val;
         CSR_REPLACE_LENGTH: cfg.replace_length = val[3:0];
         CSR_REPLACE_ALL:    cfg.replace_all    = val[0];
         CSR_ADDRESS_MODE:   cfg.address_mode   = val[1:0];
         CSR_ADDRESS_LINE:   cfg.address_line   = val[23:0];
         default:            ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic lls_req_type req_of(logic hb, logic [7:0] b, logic le, logic ll,
                                          logic fs);
      lls_req_type r;
      r.has_byte   = hb;
      r.data_byte  = b;
      r.line_end   = le;
      r.last_line  = ll;
      r.file_start = fs;
      return r;
   endfunction

   // A single typed result is always the last one of its item.
   function automatic lls_rsp_type rsp_of(logic hb, logic [7:0] b, logic le);
      lls_rsp_type r;
      r.out_has_byte = hb;
      r.out_byte     = b;
      r.out_line_end = le;
      r.last         = 1'b1;
      return r;
   endfunction

   function automatic void row_send(lls_req_type item, want_kind_type wk, lls_rsp_type want);
      dir_row_type r;
      r           = '0;
      r.kind      = ROW_SEND;
      r.item      = item;
      r.want_kind = wk;
      r.want      = want;
      directed_rows.push_back(r);
   endfunction

   function automatic void row_write(lls_csr_type idx, logic [63:0] val);
      dir_row_type r;
      r           = '0;
      r.kind      = ROW_WRITE;
      r.reg_index = idx;
      r.value     = val;
      directed_rows.push_back(r);
   endfunction

   // Half pattern bytes, most of the rest a few letters, so matches and near misses are common.
   function automatic logic [7:0] pick_byte(int flen);
      int roll, k;
      roll = $urandom_range(0, 99);
      if (flen != 0 && roll < 50) begin
         k = $urandom_range(0, flen - 1);
         return cfg.find_bytes[8*k +: 8];
      end
      if (roll < 80)
         return 8'h61 + 8'($urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   // Append one well-formed file of one to four lines, now and then with a noise item.
   function automatic void queue_file();
      logic [7:0]  line_bytes [$];
      logic [11:0] noise_bits;
      logic        first, on_byte, final_line;
      int          lines, len, flen, ln, k;
      flen  = (cfg.find_length > FIND_MAX) ? FIND_MAX : cfg.find_length;
      lines = $urandom_range(1, 4);
      first = 1'b1;
      for (ln = 0; ln < lines; ln++) begin
         final_line = (ln == lines - 1);
         line_bytes.delete();
         len = $urandom_range(0, 10);
         while (line_bytes.size() < len) begin
            if (flen != 0 && $urandom_range(0, 1) == 1) begin
               for (k = 0; k < flen; k++)
                  line_bytes.push_back(cfg.find_bytes[8*k +: 8]);
            end else begin
               line_bytes.push_back(pick_byte(flen));
            end
         end
         // end the line on its last byte, or with a bare line-end item
         on_byte = (line_bytes.size() != 0) && ($urandom_range(0, 9) < 6);
         for (k = 0; k < line_bytes.size(); k++) begin
            stim_items.push_back(req_of(1'b1, line_bytes[k],
                                        on_byte && (k == line_bytes.size() - 1),
                                        final_line, first));
            first = 1'b0;
         end
         if (!on_byte) begin
            stim_items.push_back(req_of(1'b0, 8'h00, 1'b1, final_line, first));
            first = 1'b0;
         end
         if ($urandom_range(0, 9) == 0) begin
            noise_bits = 12'($urandom_range(0, 4095));
            stim_items.push_back(noise_bits);
         end
      end
   endfunction

   // Write every register; the first phases pin down the extremes.
   task automatic configure_phase(input int p);
      logic [63:0] pattern, swap;
      int          flen_w, rlen_w, all_w, mode_w, line_w, i;
      pattern = {$urandom, $urandom};
      for (i = 0; i < FIND_MAX; i++)
         if ($urandom_range(0, 3) != 0)
            pattern[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      swap   = {$urandom, $urandom};
      flen_w = $urandom_range(1, 4);
      rlen_w = $urandom_range(0, REPLACE_MAX);
      all_w  = $urandom_range(0, 1);
      mode_w = $urandom_range(0, 3);
      line_w = $urandom_range(1, 4);
      case (p)
         0: begin
            flen_w = 1;
            rlen_w = REPLACE_MAX;
            all_w  = 1;
            mode_w = ADDR_EVERY;
         end
         1: begin
            pattern = '1;
            flen_w  = FIND_MAX;
            rlen_w  = 0;
            all_w   = 0;
            mode_w  = ADDR_FINAL_LINE;
         end
         2: begin
            flen_w = 15;
            rlen_w = 15;
            all_w  = 1;
            mode_w = ADDR_NUMBERED;
            line_w = 2;
         end
         3: begin
            pattern = '0;
            flen_w  = 0;
            mode_w  = ADDR_UNUSED;
         end
         4: begin
            swap   = '1;
            all_w  = 1;
            mode_w = ADDR_NUMBERED;
            line_w = LINE_MAX;
         end
         default: ;
      endcase
      write_reg(CSR_FIND_BYTES, pattern);
      write_reg(CSR_FIND_LENGTH, 64'(flen_w));
      write_reg(CSR_REPLACE_BYTES, swap);
      write_reg(CSR_REPLACE_LENGTH, 64'(rlen_w));
      write_reg(CSR_REPLACE_ALL, 64'(all_w));
      write_reg(CSR_ADDRESS_MODE, 64'(mode_w));
      write_reg(CSR_ADDRESS_LINE, 64'(line_w));
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      int p, k;
      cfg              = '0;
      cfg.address_line = 24'd1;
      held_n           = 0;
      line_no          = 24'd1;
      replaced         = 1'b0;
      foreach (held_bytes[i]) held_bytes[i] = 8'h00;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: substitution is off, so a byte comes straight back and the
      // marker items give only what they mark.
      row_send(req_of(1'b1, 8'h00, 1'b0, 1'b0, 1'b0), WANT_ONE, rsp_of(1'b1, 8'h00, 1'b0));
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b1, 1'b0), WANT_ONE, rsp_of(1'b1, 8'hFF, 1'b0));
      row_send(req_of(1'b0, 8'hA5, 1'b0, 1'b0, 1'b0), WANT_NONE, '0);
      row_send(req_of(1'b0, 8'h5A, 1'b1, 1'b0, 1'b0), WANT_ONE, rsp_of(1'b0, 8'h00, 1'b1));
      row_send(req_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1), WANT_NONE, '0);

      // "ab" -> "XYZ" on every match; junk above the pattern length must be ignored
      row_write(CSR_FIND_BYTES, 64'hA5A5_A5A5_A5A5_6261);
      row_write(CSR_FIND_LENGTH, 2);
      row_write(CSR_REPLACE_BYTES, 64'h0000_0000_005A_5958);
      row_write(CSR_REPLACE_LENGTH, 3);
      row_write(CSR_REPLACE_ALL, 1);
      row_send(req_of(1'b1, 8'h61, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'h62, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      // near miss then match, line ends on the byte
      row_send(req_of(1'b1, 8'h61, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'h61, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'h62, 1'b1, 1'b0, 1'b0), WANT_MODEL, '0);
      // file start in the middle of a line flushes without a line end
      row_send(req_of(1'b1, 8'h61, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'h71, 1'b0, 1'b0, 1'b1), WANT_MODEL, '0);
      row_send(req_of(1'b0, 8'h00, 1'b1, 1'b0, 1'b0), WANT_MODEL, '0);

      // oversized lengths, first match only, then shrink the pattern under a part-filled window
      row_write(CSR_FIND_BYTES, '1);
      row_write(CSR_FIND_LENGTH, 15);
      row_write(CSR_REPLACE_BYTES, 64'h0807_0605_0403_0201);
      row_write(CSR_REPLACE_LENGTH, 15);
      row_write(CSR_REPLACE_ALL, 0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_write(CSR_FIND_LENGTH, 2);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);

      // deletion, unused address mode, address line zero, last-line only
      row_write(CSR_REPLACE_LENGTH, 0);
      row_write(CSR_ADDRESS_MODE, ADDR_UNUSED);
      row_send(req_of(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0), WANT_MODEL, '0);
      row_write(CSR_ADDRESS_MODE, ADDR_NUMBERED);
      row_write(CSR_ADDRESS_LINE, 0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b0, 8'h00, 1'b1, 1'b0, 1'b0), WANT_MODEL, '0);
      row_write(CSR_ADDRESS_MODE, ADDR_FINAL_LINE);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b1, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b1, 8'hFF, 1'b0, 1'b1, 1'b0), WANT_MODEL, '0);
      row_send(req_of(1'b0, 8'h00, 1'b1, 1'b1, 1'b0), WANT_MODEL, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_quiet();
            write_reg(directed_rows[i].reg_index, directed_rows[i].value);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].want_kind,
                      directed_rows[i].want);
         end
      end

      // Random files, one setting per phase; phase 2 runs with no idling on either side.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_quiet();
         configure_phase(p);
         calm <= (p == 2);
         stim_items.delete();
         while (stim_items.size() < PHASE_ITEMS) queue_file();
         for (k = 0; k < stim_items.size(); k++) begin
            if (k == stim_items.size() / 2) begin
               // hold the sender until the block has caught up, often mid-line
               wait_quiet();
               if (p >= 5)
                  write_reg(CSR_FIND_LENGTH, 64'($urandom_range(1, 3)));
            end
            send_item(stim_items[k], WANT_MODEL, '0);
         end
      end
      calm <= 1'b0;

      wait_quiet();
      if (failures == 0)
         $display("line_literal_substitution test passed");
      else
         $display("line_literal_substitution test failed");
      $finish;
   end

endmodule
